FILE: sv/pirb_pkg.sv
// package for the rotated-box point test: widths, opcodes, quarter-wave sine table
// and the trig helper used at box load time. no dependencies.
package pirb_pkg;

  localparam int MaxBoxes = 64;
  localparam int SlotW = 6;
  localparam int CoordW = 24;
  localparam int SizeW = 16;
  localparam int TrigW = 16;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // one stored box entry
  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic [SizeW-1:0]         sx;
    logic [SizeW-1:0]         sy;
    logic [SizeW-1:0]         sz;
    logic signed [TrigW-1:0]  cosv;
    logic signed [TrigW-1:0]  sinv;
  } box_t;

  // quarter-wave sine samples, Q1.15
  function automatic logic [15:0] qsin_tab(input logic [5:0] k);
    logic [15:0] v;
    begin
      unique case (k)
        6'd0: v = 16'd0;      6'd1: v = 16'd1608;   6'd2: v = 16'd3212;
        6'd3: v = 16'd4808;   6'd4: v = 16'd6393;   6'd5: v = 16'd7962;
        6'd6: v = 16'd9512;   6'd7: v = 16'd11039;  6'd8: v = 16'd12540;
        6'd9: v = 16'd14010;  6'd10: v = 16'd15447; 6'd11: v = 16'd16846;
        6'd12: v = 16'd18205; 6'd13: v = 16'd19520; 6'd14: v = 16'd20788;
        6'd15: v = 16'd22006; 6'd16: v = 16'd23170; 6'd17: v = 16'd24279;
        6'd18: v = 16'd25330; 6'd19: v = 16'd26320; 6'd20: v = 16'd27245;
        6'd21: v = 16'd28106; 6'd22: v = 16'd28898; 6'd23: v = 16'd29622;
        6'd24: v = 16'd30274; 6'd25: v = 16'd30853; 6'd26: v = 16'd31357;
        6'd27: v = 16'd31786; 6'd28: v = 16'd32138; 6'd29: v = 16'd32413;
        6'd30: v = 16'd32610; 6'd31: v = 16'd32729;
        default: v = 16'd32767;
      endcase
      return v;
    end
  endfunction

  // interpolated quarter sine, u in 0..16384
  function automatic logic [15:0] quarter_eval(input logic [14:0] u);
    logic [5:0]  i;
    logic [8:0]  f;
    logic [15:0] a;
    logic [15:0] d;
    logic [24:0] p;
    begin
      i = u[14:9];
      f = u[8:0];
      a = qsin_tab(i);
      d = qsin_tab(i + 6'd1) - a;
      p = 25'(d) * 25'(f) + 25'd256;
      if (u[14]) return 16'd32767;
      return a + 16'(p[24:9]);
    end
  endfunction

  // Q1.15 sine of a 16-bit heading
  function automatic logic [15:0] sine_q15(input logic [15:0] h);
    logic [14:0] u;
    logic [15:0] s;
    begin
      u = {1'b0, h[13:0]};
      s = h[14] ? quarter_eval(15'd16384 - u) : quarter_eval(u);
      return h[15] ? 16'(-s) : s;
    end
  endfunction

endpackage

FILE: sv/pirb_trig.sv
// registered sine and cosine of a heading.
// depends on pirb_pkg.
module pirb_trig import pirb_pkg::*; (
  input  logic               clk,
  input  logic [15:0]        heading,
  output logic signed [15:0] cosv,
  output logic signed [15:0] sinv
);

  // cosine as sine shifted by a quarter turn
  always_ff @(posedge clk) begin
    sinv <= sine_q15(heading);
    cosv <= sine_q15(heading + 16'd16384);
  end

endmodule

FILE: sv/pirb_test.sv
// pipelined box test: one stored box and the point in, one inside flag out.
// three stages: differences, products, compares. depends on pirb_pkg.
module pirb_test import pirb_pkg::*; (
  input  logic                     clk,
  input  logic                     in_vld,
  input  logic [SlotW-1:0]         in_slot,
  input  box_t                     box,
  input  logic signed [CoordW-1:0] px,
  input  logic signed [CoordW-1:0] py,
  input  logic signed [CoordW-1:0] pz,
  input  logic [7:0]               margin,
  input  logic                     rst,
  output logic                     out_vld,
  output logic [SlotW-1:0]         out_slot,
  output logic                     out_hit
);

  logic               v1, v2;
  logic [SlotW-1:0]   s1, s2;
  logic signed [24:0] dx, dy;
  logic               zok1, zok2;
  logic [SizeW-1:0]   sx1, sy1, sx2, sy2;
  logic signed [15:0] c1, n1;
  logic signed [40:0] pxc, pys, pyc, pxs;
  logic signed [24:0] dz;
  logic [25:0]        adz;
  logic signed [26:0] lx, ly;
  logic [26:0]        alx, aly;
  logic [27:0]        limx, limy;

  always_comb begin
    dz  = 25'(pz) - 25'(box.cz);
    adz = dz[24] ? 26'(-dz) : 26'(dz);
  end

  // stage 1: center differences and z test
  always_ff @(posedge clk) begin
    dx   <= 25'(px) - 25'(box.cx);
    dy   <= 25'(py) - 25'(box.cy);
    zok1 <= {adz, 1'b0} <= 27'(box.sz);
    sx1  <= box.sx;
    sy1  <= box.sy;
    c1   <= box.cosv;
    n1   <= box.sinv;
    s1   <= in_slot;
  end

  // stage 2: rotation products
  always_ff @(posedge clk) begin
    pxc  <= dx * c1;
    pys  <= dy * n1;
    pyc  <= dy * c1;
    pxs  <= dx * n1;
    zok2 <= zok1;
    sx2  <= sx1;
    sy2  <= sy1;
    s2   <= s1;
  end

  always_comb begin
    lx   = 27'(pxc >>> 15) + 27'(pys >>> 15);
    ly   = 27'(pyc >>> 15) - 27'(pxs >>> 15);
    alx  = lx[26] ? 27'(-lx) : 27'(lx);
    aly  = ly[26] ? 27'(-ly) : 27'(ly);
    limx = 28'(sx2) + 28'({margin, 1'b0});
    limy = 28'(sy2) + 28'({margin, 1'b0});
  end

  // stage 3: xy compares
  always_ff @(posedge clk) begin
    out_hit  <= zok2 && ({alx, 1'b0} < limx) && ({aly, 1'b0} < limy);
    out_slot <= s2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v1 <= in_vld;
      v2 <= v1;
      out_vld <= v2;
    end
  end

endmodule

FILE: sv/points_in_rotated_boxes.sv
// top level: box table memory, load/query/clear sequencer and result register.
// depends on pirb_pkg, pirb_trig and pirb_test.
//
// A load writes the box entry and its valid mark in the LOAD state; a clear or
// an unused opcode returns nothing. A query reads the box memory one slot per
// cycle through its single read port and runs the box test pipeline. The result
// is registered once the last of the 64 slots leaves the pipeline, and the next
// transaction is taken only after that. A result held by a receiver
// stall also stalls the input. Valid marks are flip-flops cleared by reset and
// by a clear; box entries are undefined until loaded.
module points_in_rotated_boxes import pirb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [7:0]               cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               op,
  input  logic [SlotW-1:0]         box_slot,
  input  logic signed [CoordW-1:0] pos_x,
  input  logic signed [CoordW-1:0] pos_y,
  input  logic signed [CoordW-1:0] pos_z,
  input  logic [SizeW-1:0]         size_x,
  input  logic [SizeW-1:0]         size_y,
  input  logic [SizeW-1:0]         size_z,
  input  logic [15:0]              heading,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [MaxBoxes-1:0]      inside_mask,
  output logic                     any_inside
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOAD  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]               state;
  logic [7:0]               margin;
  logic [MaxBoxes-1:0]      box_valid;
  box_t                     mem [MaxBoxes];
  box_t                     rd_box;
  logic [SlotW:0]           scan_cnt;
  logic                     rd_vld;
  logic [SlotW-1:0]         rd_slot;
  logic [SlotW-1:0]         ld_slot;
  logic signed [CoordW-1:0] qx, qy, qz;
  logic [SizeW-1:0]         lsx, lsy, lsz;
  logic [MaxBoxes-1:0]      acc;
  logic signed [15:0]       cosv, sinv;
  logic                     t_vld, t_hit;
  logic [SlotW-1:0]         t_slot;
  logic                     accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE) || (out_valid && out_stall);
  assign accept    = in_valid && !in_stall;

  pirb_trig u_trig (
    .clk(clk), .heading(heading), .cosv(cosv), .sinv(sinv)
  );

  pirb_test u_test (
    .clk(clk), .in_vld(rd_vld), .in_slot(rd_slot), .box(rd_box),
    .px(qx), .py(qy), .pz(qz), .margin(margin), .rst(rst),
    .out_vld(t_vld), .out_slot(t_slot), .out_hit(t_hit)
  );

  // box memory: write on load completion, registered read during scan
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      mem[ld_slot] <= '{cx: qx, cy: qy, cz: qz, sx: lsx, sy: lsy, sz: lsz,
                        cosv: cosv, sinv: sinv};
    end
    rd_box  <= mem[scan_cnt[SlotW-1:0]];
    rd_slot <= scan_cnt[SlotW-1:0];
  end

  // capture of the accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      qx <= pos_x; qy <= pos_y; qz <= pos_z;
      lsx <= size_x; lsy <= size_y; lsz <= size_z;
      ld_slot <= box_slot;
    end
  end

  // sequencer, valid marks, result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      margin    <= 8'd3;
      box_valid <= '0;
      scan_cnt  <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
      acc       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) margin <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      rd_vld <= 1'b0;
      if (t_vld && t_hit && box_valid[t_slot]) acc[t_slot] <= 1'b1;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            priority if (op == OP_LOAD) begin
              state <= ST_LOAD;
            end else if (op == OP_CLEAR) begin
              box_valid <= '0;
            end else if (op == OP_QUERY) begin
              state    <= ST_SCAN;
              scan_cnt <= '0;
              acc      <= '0;
            end else begin
              // unused opcode: taken with no effect
            end
          end
        end
        ST_LOAD: begin
          box_valid[ld_slot] <= 1'b1;
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          rd_vld   <= 1'b1;
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == (SlotW+1)'(MaxBoxes - 1)) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (t_vld && t_slot == SlotW'(MaxBoxes - 1)) begin
            state <= ST_IDLE;
            out_valid <= 1'b1;
            inside_mask <= acc | (MaxBoxes'(t_hit && box_valid[t_slot]) << t_slot);
            any_inside <= (acc != '0) || (t_hit && box_valid[t_slot]);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !accept) else $error("accept while busy");
  a_mask_any: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (any_inside == (inside_mask != '0))) else $error("any mismatch");
  a_mask_valid: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ((inside_mask & ~box_valid) == '0)) else $error("bad mask");
  a_load_return: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |=> (state == ST_IDLE)) else $error("load stuck");
`endif

endmodule
